@@ rtl/core/vec3_pkg.sv @@
// ----------------------------------------------------------------------------
// vec3_pkg: shared types and constants of the vector ALU
// Opcodes, pipeline geometry and the sideband record that travels with every
// transaction through the square-root and divider pipelines.
// ----------------------------------------------------------------------------
package vec3_pkg;

  localparam logic [2:0] OP_SUB   = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_CROSS = 3'd2;
  localparam logic [2:0] OP_DOT   = 3'd3;
  localparam logic [2:0] OP_NORM  = 3'd4;

  // Square root: 32 two-bit steps, two per stage.
  localparam int SQ_STEPS  = 32;
  localparam int SQ_PER    = 2;
  localparam int SQ_STAGES = SQ_STEPS / SQ_PER;

  // Divider: 17 quotient bits, two per stage, plus one dividend setup stage.
  localparam int DV_QBITS  = 17;
  localparam int DV_PER    = 2;
  localparam int DV_STAGES = (DV_QBITS + DV_PER - 1) / DV_PER;

  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    logic [2:0]  op;
    vec_t        res;
    logic [31:0] sc;
    logic [2:0]  neg;
    vec_t        mag;
  } side_t;

endpackage

@@ rtl/core/vector3_alu_top.sv @@
// ----------------------------------------------------------------------------
// vector3_alu_top: three-component Q16.16 vector ALU
// Each accepted transaction passes three multiply/sum/round stages, 16
// square-root stages, 10 divider stages and the output register. Throughput
// is one transaction per cycle for every opcode unless result_ready stalls the
// output. Synchronous reset clears all valid bits; data registers keep theirs.
// ----------------------------------------------------------------------------
module vector3_alu_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  op,
  input  logic [31:0] a_x,
  input  logic [31:0] a_y,
  input  logic [31:0] a_z,
  input  logic [31:0] b_x,
  input  logic [31:0] b_y,
  input  logic [31:0] b_z,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] r_x,
  output logic [31:0] r_y,
  output logic [31:0] r_z,
  output logic [31:0] scalar,
  output logic        zero_length
);

  // Every opcode runs through the full pipeline so that results leave in
  // order. The normalize path is the long one: the sum of squares feeds the
  // square root, whose root is the divisor.

  vec3_pkg::vec_t  a_v, b_v;
  logic            fr_valid, fr_ready;
  logic [63:0]     fr_sq;
  vec3_pkg::side_t fr_side;

  logic            sq_valid, sq_ready;
  logic [32:0]     sq_root;
  vec3_pkg::side_t sq_side;

  logic             dv_valid, dv_ready;
  logic [2:0][16:0] dv_quo;
  logic             dv_len_zero;
  vec3_pkg::side_t  dv_side;

  vec3_pkg::vec_t   res_next;
  logic             zl_next;

  assign a_v = {a_z, a_y, a_x};
  assign b_v = {b_z, b_y, b_x};

  vec3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .op        (op),
    .a         (a_v),
    .b         (b_v),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .sq        (fr_sq),
    .side      (fr_side)
  );

  vec3_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .n         (fr_sq),
    .side_in   (fr_side),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  vec3_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .len       (sq_root),
    .side_in   (sq_side),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .quo       (dv_quo),
    .len_zero  (dv_len_zero),
    .side_out  (dv_side)
  );

  // The output register takes a new transaction whenever it is empty or its
  // current one is being taken.
  assign dv_ready = ~result_valid | result_ready;

  // Normalized components never exceed one in magnitude, so the quotient
  // fits in 17 bits and only needs its sign applied.
  always_comb begin
    res_next = dv_side.res;
    zl_next  = 1'b0;
    if (dv_side.op == vec3_pkg::OP_NORM) begin
      if (dv_len_zero) begin
        res_next = '0;
        zl_next  = 1'b1;
      end else begin
        for (int c = 0; c < 3; c++) begin
          if (dv_side.neg[c]) res_next[c] = 32'd0 - {15'd0, dv_quo[c]};
          else res_next[c] = {15'd0, dv_quo[c]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (dv_ready) begin
      result_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready) begin
      r_x         <= res_next[0];
      r_y         <= res_next[1];
      r_z         <= res_next[2];
      scalar      <= dv_side.sc;
      zero_length <= zl_next;
    end
  end

endmodule

@@ rtl/core/vec3_front.sv @@
// ----------------------------------------------------------------------------
// vec3_front: multiply, combine and round stages
// Three stages: products, exact sums, rounding and saturation. Also forms the
// sum of squares for the normalize path.
// ----------------------------------------------------------------------------
module vec3_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           op,
  input  vec3_pkg::vec_t       a,
  input  vec3_pkg::vec_t       b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          sq,
  output vec3_pkg::side_t      side
);

  function automatic logic [31:0] sat66(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] rnd16(input logic signed [65:0] t);
    logic signed [65:0] s;
    s = t + 66'sd32768;
    return sat66(s >>> 16);
  endfunction

  logic               en;
  logic               v1, v2, v3;
  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];

  logic [2:0]         s1_op;
  logic signed [63:0] s1_p [6];
  logic signed [32:0] s1_sum [3];
  logic [2:0]         s1_neg;
  vec3_pkg::vec_t     s1_mag;

  logic [2:0]         s2_op;
  logic signed [65:0] s2_t [3];
  logic signed [32:0] s2_sum [3];
  logic [2:0]         s2_neg;
  vec3_pkg::vec_t     s2_mag;

  vec3_pkg::side_t    s3_side;
  logic [63:0]        s3_sq;
  vec3_pkg::side_t    side_next;

  assign en        = ~v3 | out_ready;
  assign in_ready  = en;
  assign out_valid = v3;
  assign sq        = s3_sq;
  assign side      = s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Multiplier operand selection by opcode.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (op)
      vec3_pkg::OP_CROSS: begin
        ma[0] = a[1]; mb[0] = b[2];
        ma[1] = a[2]; mb[1] = b[1];
        ma[2] = a[2]; mb[2] = b[0];
        ma[3] = a[0]; mb[3] = b[2];
        ma[4] = a[0]; mb[4] = b[1];
        ma[5] = a[1]; mb[5] = b[0];
      end
      vec3_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = a[i];
          mb[i] = b[i];
        end
      end
      vec3_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = a[i];
          mb[i] = a[i];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= op;
      for (int i = 0; i < 6; i++) s1_p[i] <= ma[i] * mb[i];
      for (int i = 0; i < 3; i++) begin
        if (op == vec3_pkg::OP_SUB)
          s1_sum[i] <= $signed({a[i][31], a[i]}) - $signed({b[i][31], b[i]});
        else
          s1_sum[i] <= $signed({a[i][31], a[i]}) + $signed({b[i][31], b[i]});
        s1_neg[i] <= a[i][31];
        s1_mag[i] <= a[i][31] ? (32'd0 - a[i]) : a[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op  <= s1_op;
      s2_sum <= s1_sum;
      s2_neg <= s1_neg;
      s2_mag <= s1_mag;
      if (s1_op == vec3_pkg::OP_CROSS) begin
        s2_t[0] <= 66'(s1_p[0]) - 66'(s1_p[1]);
        s2_t[1] <= 66'(s1_p[2]) - 66'(s1_p[3]);
        s2_t[2] <= 66'(s1_p[4]) - 66'(s1_p[5]);
      end else begin
        s2_t[0] <= 66'(s1_p[0]) + 66'(s1_p[1]) + 66'(s1_p[2]);
        s2_t[1] <= '0;
        s2_t[2] <= '0;
      end
    end
  end

  always_comb begin
    side_next     = '0;
    side_next.op  = s2_op;
    side_next.neg = s2_neg;
    side_next.mag = s2_mag;
    case (s2_op)
      vec3_pkg::OP_SUB, vec3_pkg::OP_ADD: begin
        for (int i = 0; i < 3; i++) side_next.res[i] = sat66(66'(s2_sum[i]));
      end
      vec3_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) side_next.res[i] = rnd16(s2_t[i]);
      end
      vec3_pkg::OP_DOT: side_next.sc = rnd16(s2_t[0]);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= side_next;
      s3_sq   <= s2_t[0][63:0];
    end
  end

endmodule

@@ rtl/core/vec3_sqrt.sv @@
// ----------------------------------------------------------------------------
// vec3_sqrt: pipelined integer square root
// Digit-by-digit root of a 64-bit value, two result bits per stage.
// ----------------------------------------------------------------------------
module vec3_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       n,
  input  vec3_pkg::side_t   side_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [32:0]       root,
  output vec3_pkg::side_t   side_out
);

  localparam int NS = vec3_pkg::SQ_STAGES;

  logic            en;
  logic            v_q    [NS];
  logic [63:0]     n_q    [NS];
  logic [63:0]     r_q    [NS];
  vec3_pkg::side_t side_q [NS];

  assign en        = ~v_q[NS-1] | out_ready;
  assign in_ready  = en;
  assign out_valid = v_q[NS-1];
  assign root      = r_q[NS-1][32:0];
  assign side_out  = side_q[NS-1];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic            v_in;
    logic [63:0]     n_in, r_in, n_nx, r_nx;
    vec3_pkg::side_t s_in;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign n_in = n;
      assign r_in = '0;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign n_in = n_q[i-1];
      assign r_in = r_q[i-1];
      assign s_in = side_q[i-1];
    end

    always_comb begin
      logic [63:0] bt;
      n_nx = n_in;
      r_nx = r_in;
      for (int j = 0; j < vec3_pkg::SQ_PER; j++) begin
        bt = 64'd1 << (62 - 2 * (i * vec3_pkg::SQ_PER + j));
        if (n_nx >= r_nx + bt) begin
          n_nx = n_nx - (r_nx + bt);
          r_nx = (r_nx >> 1) + bt;
        end else begin
          r_nx = r_nx >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[i]    <= n_nx;
        r_q[i]    <= r_nx;
        side_q[i] <= s_in;
      end
    end
  end

endmodule

@@ rtl/core/vec3_div.sv @@
// ----------------------------------------------------------------------------
// vec3_div: pipelined restoring divider, three lanes
// Divides each rounded, scaled magnitude by the length, two quotient bits per
// stage (one in the last stage) after a dividend setup stage.
// ----------------------------------------------------------------------------
module vec3_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [32:0]       len,
  input  vec3_pkg::side_t   side_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0][16:0]  quo,
  output logic              len_zero,
  output vec3_pkg::side_t   side_out
);

  localparam int NS = vec3_pkg::DV_STAGES + 1;
  localparam int QB = vec3_pkg::DV_QBITS;

  logic             en;
  logic             v_q    [NS];
  logic [32:0]      len_q  [NS];
  logic [2:0][48:0] rem_q  [NS];
  logic [2:0][16:0] quo_q  [NS];
  vec3_pkg::side_t  side_q [NS];

  assign en        = ~v_q[NS-1] | out_ready;
  assign in_ready  = en;
  assign out_valid = v_q[NS-1];
  assign quo       = quo_q[NS-1];
  assign len_zero  = (len_q[NS-1] == 33'd0);
  assign side_out  = side_q[NS-1];

  // Setup: dividend is the magnitude scaled by 2^16 plus half the length.
  always_ff @(posedge clk) begin
    if (en) begin
      len_q[0]  <= len;
      side_q[0] <= side_in;
      quo_q[0]  <= '0;
      for (int c = 0; c < 3; c++)
        rem_q[0][c] <= {1'b0, side_in.mag[c], 16'd0} + 49'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
    end
  end

  for (genvar i = 1; i < NS; i++) begin : g_stage
    logic [2:0][48:0] rem_nx;
    logic [2:0][16:0] quo_nx;

    always_comb begin
      logic [49:0] trial;
      int          k;
      rem_nx = rem_q[i-1];
      quo_nx = quo_q[i-1];
      for (int j = 0; j < vec3_pkg::DV_PER; j++) begin
        k = QB - 1 - (i - 1) * vec3_pkg::DV_PER - j;
        if (k >= 0) begin
          for (int c = 0; c < 3; c++) begin
            trial = {1'b0, rem_nx[c]} - ({17'd0, len_q[i-1]} << k);
            if (!trial[49]) rem_nx[c] = trial[48:0];
            quo_nx[c] = {quo_nx[c][15:0], ~trial[49]};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_q[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_q[i]  <= len_q[i-1];
        side_q[i] <= side_q[i-1];
        rem_q[i]  <= rem_nx;
        quo_q[i]  <= quo_nx;
      end
    end
  end

endmodule

@@ rtl/core/vec3_chk.sv @@
// ----------------------------------------------------------------------------
// vec3_chk: port checker for the vector ALU
// Watches the result channel for reset behavior, stall stability and field
// consistency between the vector, scalar and zero-length outputs.
// ----------------------------------------------------------------------------
module vec3_chk (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] r_x,
  input logic [31:0] r_y,
  input logic [31:0] r_z,
  input logic [31:0] scalar,
  input logic        zero_length
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(r_x)
      && $stable(r_y) && $stable(r_z))
    else $error("stalled result changed");

  a_hold_side: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(scalar) && $stable(zero_length))
    else $error("stalled scalar or flag changed");

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && zero_length |-> r_x == 32'd0 && r_y == 32'd0
      && r_z == 32'd0 && scalar == 32'd0)
    else $error("zero length with nonzero fields");

  a_scalar_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && scalar != 32'd0 |-> r_x == 32'd0 && r_y == 32'd0
      && r_z == 32'd0 && !zero_length)
    else $error("dot product with vector fields set");

endmodule

bind vector3_alu_top vec3_chk u_vec3_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .r_x          (r_x),
  .r_y          (r_y),
  .r_z          (r_z),
  .scalar       (scalar),
  .zero_length  (zero_length)
);
